[rtl/core/tmp_pkg.sv]
// ----------------------------------------------------------------------------
// tmp_pkg
// Shared types and constants of the trapezoid motion profile generator.
// ----------------------------------------------------------------------------
package tmp_pkg;

  // Field and datapath widths
  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned POS_W     = 24;
  localparam int unsigned IDX_W     = 32;
  localparam int unsigned U_W       = 48;
  localparam int unsigned QW        = 32;  // quotient bits, one per divider stage
  localparam int unsigned MPOS_W    = 34;
  localparam int unsigned WPOS_W    = 36;
  localparam int unsigned VEL_W     = 17;
  localparam int unsigned ACC_W     = 32;
  localparam int unsigned TOTAL_W   = 32;
  localparam int unsigned SETUP_W   = 36;  // setup divider numerator width
  localparam int unsigned SETUP_CNT_W = 6;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_POS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_POS   = 2'd2;

  // Profile scale factors
  localparam int unsigned K_BLEND  = 150;
  localparam int unsigned K_CRUISE = 500;
  localparam int unsigned K_END    = 650;
  localparam int unsigned K_TOTAL  = 1300;
  localparam int unsigned K_ACC_N  = 10;
  localparam int unsigned K_ACC_D  = 3;
  localparam int unsigned K_MILLI  = 1000;

  typedef enum logic [1:0] {
    PH_BLEND_IN,
    PH_CRUISE,
    PH_BLEND_OUT,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    SU_IDLE,
    SU_TOTAL,
    SU_ACCEL
  } setup_state_e;

  // Coefficients derived from configuration
  typedef struct packed {
    logic                     err;
    logic                     dir_neg;
    logic [SPEED_W-1:0]       speed;
    logic [31:0]              b1;
    logic [32:0]              b2;
    logic [33:0]              b3;
    logic signed [WPOS_W-1:0] base_i;
    logic signed [WPOS_W-1:0] base_f;
    logic [TOTAL_W-1:0]       total;
    logic signed [ACC_W-1:0]  acc_plus;
    logic signed [ACC_W-1:0]  acc_minus;
  } coef_t;

  // Request payload through the divider pipeline
  typedef struct packed {
    phase_e                   phase;
    logic signed [WPOS_W-1:0] cpos;
    logic [QW-1:0]            rp;
    logic [QW-1:0]            shp;
    logic [QW-1:0]            rv;
    logic [QW-1:0]            shv;
  } pipe_t;

endpackage

[rtl/core/tmp_coef.sv]
// ----------------------------------------------------------------------------
// tmp_coef
// Configuration registers and the setup unit that derives the profile
// coefficients, with a shared restoring divider for move length and accel.
// ----------------------------------------------------------------------------
module tmp_coef import tmp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [POS_W-1:0]     cfg_data_i,
  output coef_t                coef_o,
  output logic                 busy_o
);

  logic [SPEED_W-1:0]      speed_q;
  logic signed [POS_W-1:0] start_q, target_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q  <= SPEED_W'(1);
      start_q  <= '0;
      target_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CRUISE_SPEED: speed_q  <= cfg_data_i[SPEED_W-1:0];
        REG_START_POS:    start_q  <= cfg_data_i;
        REG_TARGET_POS:   target_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Distance and direction
  logic [POS_W:0]   diff, neg_diff;
  logic [POS_W-1:0] distance;
  logic             dir_neg;

  assign diff     = {target_q[POS_W-1], target_q} - {start_q[POS_W-1], start_q};
  assign neg_diff = -diff;
  assign dir_neg  = diff[POS_W];
  assign distance = dir_neg ? neg_diff[POS_W-1:0] : diff[POS_W-1:0];

  // Setup divider
  setup_state_e           state_q, state_d;
  logic                   pending_q;
  logic [SETUP_CNT_W-1:0] cnt_q;
  logic [SETUP_W-1:0]     num_q, den_q, quo_q, quo_n, rem_q, rem_n;
  logic [SETUP_W:0]       trial, trial_sub;
  logic                   ge, last, start, fin_total, fin_acc;
  logic [TOTAL_W-1:0]     total_q;
  logic signed [ACC_W-1:0] acc_plus_q, acc_minus_q;
  logic [ACC_W-1:0]       amag;

  assign trial     = {rem_q, num_q[SETUP_W-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign ge        = !trial_sub[SETUP_W];
  assign rem_n     = ge ? trial_sub[SETUP_W-1:0] : trial[SETUP_W-1:0];
  assign quo_n     = {quo_q[SETUP_W-2:0], ge};
  assign last      = (cnt_q == SETUP_CNT_W'(SETUP_W - 1));
  assign amag      = {1'b0, quo_n[ACC_W-2:0]};

  // Sequence the two divisions
  always_comb begin
    state_d   = state_q;
    start     = 1'b0;
    fin_total = 1'b0;
    fin_acc   = 1'b0;
    unique case (state_q)
      SU_IDLE: begin
        if (pending_q) begin
          state_d = SU_TOTAL;
          start   = 1'b1;
        end
      end
      SU_TOTAL: begin
        if (last) begin
          state_d   = SU_ACCEL;
          fin_total = 1'b1;
        end
      end
      SU_ACCEL: begin
        if (last) begin
          state_d = SU_IDLE;
          fin_acc = 1'b1;
        end
      end
      default: state_d = SU_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SU_IDLE;
      pending_q <= 1'b1;
      cnt_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        pending_q <= 1'b1;
      end else if (start) begin
        pending_q <= 1'b0;
      end
      if (start || fin_total) begin
        cnt_q <= '0;
      end else if (state_q != SU_IDLE) begin
        cnt_q <= cnt_q + SETUP_CNT_W'(1);
      end
    end
  end

  // Divider datapath
  always_ff @(posedge clk_i) begin
    if (start) begin
      num_q <= SETUP_W'(distance) * SETUP_W'(K_TOTAL) + SETUP_W'(speed_q);
      den_q <= SETUP_W'({speed_q, 1'b0});
      rem_q <= '0;
      quo_q <= '0;
    end else if (fin_total) begin
      total_q <= (quo_n[SETUP_W-1:TOTAL_W] != '0) ? '1 : quo_n[TOTAL_W-1:0];
      num_q   <= SETUP_W'(speed_q) * SETUP_W'(speed_q) * SETUP_W'(K_ACC_N);
      den_q   <= SETUP_W'(distance) * SETUP_W'(K_ACC_D);
      rem_q   <= '0;
      quo_q   <= '0;
    end else if (state_q != SU_IDLE) begin
      num_q <= {num_q[SETUP_W-2:0], 1'b0};
      rem_q <= rem_n;
      quo_q <= quo_n;
    end
    // Saturate acceleration magnitude to the signed range
    if (fin_acc) begin
      if (quo_n[SETUP_W-1:ACC_W-1] != '0) begin
        acc_plus_q  <= {1'b0, {(ACC_W-1){1'b1}}};
        acc_minus_q <= {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
        acc_plus_q  <= amag;
        acc_minus_q <= -amag;
      end
    end
  end

  // Register derived coefficients
  coef_t coef_q;
  always_ff @(posedge clk_i) begin
    coef_q.err       <= (distance == '0) || (speed_q == '0);
    coef_q.dir_neg   <= dir_neg;
    coef_q.speed     <= speed_q;
    coef_q.b1        <= 32'(distance) * 32'(K_BLEND);
    coef_q.b2        <= 33'(distance) * 33'(K_CRUISE);
    coef_q.b3        <= 34'(distance) * 34'(K_END);
    coef_q.base_i    <= WPOS_W'(start_q) * $signed(WPOS_W'(K_MILLI));
    coef_q.base_f    <= WPOS_W'(target_q) * $signed(WPOS_W'(K_MILLI));
    coef_q.total     <= total_q;
    coef_q.acc_plus  <= acc_plus_q;
    coef_q.acc_minus <= acc_minus_q;
  end

  assign coef_o = coef_q;
  assign busy_o = pending_q || (state_q != SU_IDLE);

  // Any write must start a new setup pass
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy_o)
    else $error("setup not started after register write");

endmodule

[rtl/core/tmp_front.sv]
// ----------------------------------------------------------------------------
// tmp_front
// Front stages: scale the sample index, classify the phase and form the
// products that the divider pipeline divides by the blend length.
// ----------------------------------------------------------------------------
module tmp_front import tmp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [IDX_W-1:0] sample_i,
  input  coef_t            coef_i,
  output logic             valid_o,
  input  logic             ready_i,
  output pipe_t            data_o
);

  logic           v1_q, v2_q, v3_q;
  logic           r1, r2, r3;
  logic [U_W-1:0] u_q;
  phase_e         ph_q, ph_d;
  logic [QW-1:0]  x_q, x_d;
  logic [33:0]    cd_q;
  pipe_t          data_q, data_d;

  assign r3      = !v3_q || ready_i;
  assign r2      = !v2_q || r3;
  assign r1      = !v1_q || r2;
  assign ready_o = r1;

  // Classify the phase
  logic [U_W-1:0] w;
  logic [U_W:0]   dbl;
  assign w   = U_W'(coef_i.b3) - u_q;
  assign dbl = {u_q, 1'b0} - (U_W+1)'(coef_i.b1);

  always_comb begin
    priority if (u_q < U_W'(coef_i.b1)) begin
      ph_d = PH_BLEND_IN;
    end else if (u_q < U_W'(coef_i.b2)) begin
      ph_d = PH_CRUISE;
    end else if (u_q <= U_W'(coef_i.b3)) begin
      ph_d = PH_BLEND_OUT;
    end else begin
      ph_d = PH_DONE;
    end
    x_d = (ph_d == PH_BLEND_IN) ? u_q[QW-1:0] : w[QW-1:0];
  end

  // Form products and the cruise position
  logic [2*QW-1:0]          sq;
  logic [U_W-1:0]           vx;
  logic signed [WPOS_W-1:0] cd_ext;
  assign sq     = (2*QW)'(x_q) * (2*QW)'(x_q);
  assign vx     = U_W'(x_q) * U_W'(coef_i.speed);
  assign cd_ext = $signed({2'b00, cd_q});

  always_comb begin
    data_d.phase = ph_q;
    data_d.cpos  = coef_i.dir_neg ? coef_i.base_i - cd_ext : coef_i.base_i + cd_ext;
    data_d.rp    = sq[2*QW-1:QW];
    data_d.shp   = sq[QW-1:0];
    data_d.rv    = QW'(vx[U_W-1:QW]);
    data_d.shv   = vx[QW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (r1 && valid_i) u_q <= U_W'(sample_i) * U_W'(coef_i.speed);
    if (r2 && v1_q) begin
      ph_q <= ph_d;
      x_q  <= x_d;
      cd_q <= dbl[33:0];
    end
    if (r3 && v2_q) data_q <= data_d;
  end

  assign valid_o = v3_q;
  assign data_o  = data_q;

endmodule

[rtl/core/tmp_div_stage.sv]
// ----------------------------------------------------------------------------
// tmp_div_stage
// One restoring division step for the position and velocity quotients,
// followed by a pipeline register.
// ----------------------------------------------------------------------------
module tmp_div_stage import tmp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  pipe_t         data_i,
  input  logic [QW-1:0] divisor_i,
  output logic          valid_o,
  input  logic          ready_i,
  output pipe_t         data_o
);

  logic  valid_q;
  pipe_t data_q, data_d;
  logic [QW:0] tp, tv, sp, sv;

  assign ready_o = !valid_q || ready_i;

  // Shift in the next numerator bit, subtract when it fits
  assign tp = {data_i.rp, data_i.shp[QW-1]};
  assign tv = {data_i.rv, data_i.shv[QW-1]};
  assign sp = tp - {1'b0, divisor_i};
  assign sv = tv - {1'b0, divisor_i};

  always_comb begin
    data_d     = data_i;
    data_d.rp  = sp[QW] ? tp[QW-1:0] : sp[QW-1:0];
    data_d.shp = {data_i.shp[QW-2:0], !sp[QW]};
    data_d.rv  = sv[QW] ? tv[QW-1:0] : sv[QW-1:0];
    data_d.shv = {data_i.shv[QW-2:0], !sv[QW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/core/tmp_back.sv]
// ----------------------------------------------------------------------------
// tmp_back
// Back stages: round the quotients, select by phase and hold the result in
// the output register.
// ----------------------------------------------------------------------------
module tmp_back import tmp_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  pipe_t                     data_i,
  input  coef_t                     coef_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [MPOS_W-1:0]  out_position_milli_o,
  output logic signed [VEL_W-1:0]   out_velocity_o,
  output logic signed [ACC_W-1:0]   out_acceleration_o,
  output logic [TOTAL_W-1:0]        out_total_samples_o,
  output logic                      out_move_done_o,
  output logic                      out_profile_error_o
);

  logic r1, r2, v1_q, ov_q;
  assign r2      = !ov_q || !out_stall_i;
  assign r1      = !v1_q || r2;
  assign ready_o = r1;

  // First stage: base plus or minus quotient, rounding decisions
  logic                     sneg_d;
  logic signed [WPOS_W-1:0] base, qext, b_d;
  logic [QW:0]              two_rp, two_rv, b1x;
  logic                     rnz;

  assign sneg_d = (data_i.phase == PH_BLEND_IN) ? coef_i.dir_neg : !coef_i.dir_neg;
  assign base   = (data_i.phase == PH_BLEND_IN) ? coef_i.base_i : coef_i.base_f;
  assign qext   = $signed({{(WPOS_W-QW){1'b0}}, data_i.shp});
  assign b_d    = sneg_d ? base - qext : base + qext;
  assign two_rp = {data_i.rp, 1'b0};
  assign two_rv = {data_i.rv, 1'b0};
  assign b1x    = {1'b0, coef_i.b1};
  assign rnz    = (data_i.rp != '0);

  phase_e                   ph_q;
  logic signed [WPOS_W-1:0] b_q, cpos_q;
  logic                     sneg_q, gt_q, eq_q;
  logic [VEL_W-1:0]         vmag_q;

  always_ff @(posedge clk_i) begin
    if (r1 && valid_i) begin
      ph_q   <= data_i.phase;
      b_q    <= b_d;
      cpos_q <= data_i.cpos;
      sneg_q <= sneg_d;
      gt_q   <= rnz && (two_rp > b1x);
      eq_q   <= rnz && (two_rp == b1x);
      vmag_q <= data_i.shv[VEL_W-1:0] + VEL_W'(two_rv >= b1x);
    end
  end

  // Second stage: final rounding and phase selection
  logic                     bump;
  logic signed [WPOS_W-1:0] pos_blend, pos;
  logic signed [VEL_W-1:0]  vel, vel_blend, vel_cruise;
  logic signed [ACC_W-1:0]  acc;
  logic                     done;

  assign bump = gt_q || (eq_q && (sneg_q ? (b_q[WPOS_W-1] || (b_q == '0)) : !b_q[WPOS_W-1]));
  assign pos_blend  = bump ? (sneg_q ? b_q - WPOS_W'(1) : b_q + WPOS_W'(1)) : b_q;
  assign vel_blend  = coef_i.dir_neg ? -vmag_q : vmag_q;
  assign vel_cruise = coef_i.dir_neg ? -{1'b0, coef_i.speed} : {1'b0, coef_i.speed};

  always_comb begin
    pos  = coef_i.base_f;
    vel  = '0;
    acc  = '0;
    done = 1'b0;
    unique case (ph_q)
      PH_BLEND_IN: begin
        pos = pos_blend;
        vel = vel_blend;
        acc = coef_i.dir_neg ? coef_i.acc_minus : coef_i.acc_plus;
      end
      PH_CRUISE: begin
        pos = cpos_q;
        vel = vel_cruise;
      end
      PH_BLEND_OUT: begin
        pos = pos_blend;
        vel = vel_blend;
        acc = coef_i.dir_neg ? coef_i.acc_plus : coef_i.acc_minus;
      end
      PH_DONE: begin
        done = 1'b1;
      end
      default: ;
    endcase
    // Zero distance or speed leaves the start position
    if (coef_i.err) begin
      pos  = coef_i.base_i;
      vel  = '0;
      acc  = '0;
      done = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (r1) v1_q <= valid_i;
      if (r2) ov_q <= v1_q;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      out_position_milli_o <= pos[MPOS_W-1:0];
      out_velocity_o       <= vel;
      out_acceleration_o   <= acc;
      out_total_samples_o  <= coef_i.err ? '0 : coef_i.total;
      out_move_done_o      <= done;
      out_profile_error_o  <= coef_i.err;
    end
  end

  assign out_valid_o = ov_q;

  logic [VEL_W-1:0] vel_abs;
  assign vel_abs = out_velocity_o[VEL_W-1] ? -out_velocity_o : out_velocity_o;

  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_profile_error_o |-> out_move_done_o && (out_velocity_o == '0)
      && (out_acceleration_o == '0) && (out_total_samples_o == '0))
    else $error("error result not at rest");

  a_done_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_move_done_o |-> (out_velocity_o == '0) && (out_acceleration_o == '0))
    else $error("finished move still moving");

  a_vel_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_profile_error_o |-> vel_abs <= {1'b0, coef_i.speed})
    else $error("velocity exceeds cruise speed");

endmodule

[rtl/core/trapezoid_motion_profile.sv]
// ----------------------------------------------------------------------------
// trapezoid_motion_profile
// Point-to-point trapezoidal profile with parabolic blends.
// ----------------------------------------------------------------------------
// One sample request enters per clock while in_stall_o is low, and its result
// passes 3 front stages, 32 divider stages and 2 back stages before it leaves;
// the 32-stage divider pipeline divides by the blend length. After reset
// and after every register write the input stalls while the setup unit runs
// two 36-step divisions for move length and acceleration.
module trapezoid_motion_profile import tmp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [POS_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [IDX_W-1:0]         in_sample_index_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [MPOS_W-1:0] out_position_milli_o,
  output logic signed [VEL_W-1:0]  out_velocity_o,
  output logic signed [ACC_W-1:0]  out_acceleration_o,
  output logic [TOTAL_W-1:0]       out_total_samples_o,
  output logic                     out_move_done_o,
  output logic                     out_profile_error_o
);

  coef_t coef;
  logic  busy, front_ready;
  pipe_t      stage_data [QW+1];
  logic [QW:0] stage_valid, stage_ready;

  tmp_coef u_coef (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .coef_o (coef),
    .busy_o (busy)
  );

  // Hold off requests while coefficients are recomputed or the front stages are full
  assign in_stall_o = busy || !front_ready;

  tmp_front u_front (
    .clk_i, .rst_ni,
    .valid_i  (in_valid_i && !busy),
    .ready_o  (front_ready),
    .sample_i (in_sample_index_i),
    .coef_i   (coef),
    .valid_o  (stage_valid[0]),
    .ready_i  (stage_ready[0]),
    .data_o   (stage_data[0])
  );

  for (genvar k = 0; k < QW; k++) begin : g_div
    tmp_div_stage u_stage (
      .clk_i, .rst_ni,
      .valid_i   (stage_valid[k]),
      .ready_o   (stage_ready[k]),
      .data_i    (stage_data[k]),
      .divisor_i (coef.b1),
      .valid_o   (stage_valid[k+1]),
      .ready_i   (stage_ready[k+1]),
      .data_o    (stage_data[k+1])
    );
  end

  tmp_back u_back (
    .clk_i, .rst_ni,
    .valid_i (stage_valid[QW]),
    .ready_o (stage_ready[QW]),
    .data_i  (stage_data[QW]),
    .coef_i  (coef),
    .out_valid_o, .out_stall_i, .out_position_milli_o, .out_velocity_o,
    .out_acceleration_o, .out_total_samples_o, .out_move_done_o, .out_profile_error_o
  );

endmodule

[verif/trapezoid_motion_profile_tb.sv]
// ----------------------------------------------------------------------------
// trapezoid_motion_profile_tb
// Self-checking bench for the trapezoid motion profile generator. A local
// predictor evaluates every accepted sample request exactly in integers. It
// covers zero distance and zero speed, phase edges in both directions,
// saturated acceleration and random moves. Random gaps are applied on the
// request side and random stalls on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trapezoid_motion_profile_tb;
  import tmp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_WAIT  = 50;

  typedef struct packed {
    logic signed [MPOS_W-1:0] pos_milli;
    logic signed [VEL_W-1:0]  vel;
    logic signed [ACC_W-1:0]  acc;
    logic [TOTAL_W-1:0]       total;
    logic                     done;
    logic                     err;
  } sample_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i = '0;
  logic [POS_W-1:0]         cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [IDX_W-1:0]         in_sample_index_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [MPOS_W-1:0] out_position_milli_o;
  logic signed [VEL_W-1:0]  out_velocity_o;
  logic signed [ACC_W-1:0]  out_acceleration_o;
  logic [TOTAL_W-1:0]       out_total_samples_o;
  logic                     out_move_done_o;
  logic                     out_profile_error_o;

  // Mirrored configuration
  logic [SPEED_W-1:0]       speed_q = 16'd1;
  logic signed [POS_W-1:0]  start_q = '0;
  logic signed [POS_W-1:0]  target_q = '0;

  sample_t     expected_samples[$];
  int unsigned error_count = 0;
  int unsigned request_count = 0;
  int unsigned result_count = 0;
  int unsigned config_count = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;
  int unsigned stall_left = 0;

  trapezoid_motion_profile dut (.*);

  always #5 clk_i = ~clk_i;

  // Round base + s*num/den to nearest, ties away from zero
  function automatic longint round_near(longint base, int s, logic [127:0] num,
                                        longint unsigned den);
    logic [127:0] q, r;
    longint b;
    q = num / den;
    r = num % den;
    b = base + s * longint'(q[63:0]);
    if (r != 0) begin
      if (2 * r > den) b += s;
      else if (2 * r == den && s * (2 * b + s) > 0) b += s;
    end
    return b;
  endfunction

  // Expected profile point at one sample index
  function automatic sample_t predict_sample(logic [IDX_W-1:0] idx);
    sample_t res;
    longint qi, qf, diff, pos, vel, acc;
    int dir;
    longint unsigned d, v, u, b1, b2, b3, amag, total, w;
    qi = start_q;
    qf = target_q;
    diff = qf - qi;
    dir = diff < 0 ? -1 : 1;
    d = diff < 0 ? -diff : diff;
    v = speed_q;
    res = '0;
    if (d == 0 || v == 0) begin
      res.pos_milli = MPOS_W'(1000 * qi);
      res.done = 1'b1;
      res.err = 1'b1;
      return res;
    end
    total = (1300 * d + v) / (2 * v);
    if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
    u = longint'(idx) * v;
    b1 = 150 * d;
    b2 = 500 * d;
    b3 = 650 * d;
    amag = (10 * v * v) / (3 * d);
    vel = 0;
    acc = 0;
    if (u < b1) begin
      pos = round_near(1000 * qi, dir, 128'(u) * 128'(u), b1);
      vel = dir * longint'((2 * v * u + b1) / (2 * b1));
      acc = dir * longint'(amag);
    end else if (u < b2) begin
      pos = 1000 * qi + dir * longint'(2 * u - b1);
      vel = dir * longint'(v);
    end else if (u <= b3) begin
      w = b3 - u;
      pos = round_near(1000 * qf, -dir, 128'(w) * 128'(w), b1);
      vel = dir * longint'((2 * v * w + b1) / (2 * b1));
      acc = -dir * longint'(amag);
    end else begin
      pos = 1000 * qf;
      res.done = 1'b1;
    end
    // Saturate acceleration
    if (amag > 64'd2147483647 && acc != 0)
      acc = acc > 0 ? 64'sd2147483647 : -64'sd2147483648;
    res.pos_milli = MPOS_W'(pos);
    res.vel = VEL_W'(vel);
    res.acc = ACC_W'(acc);
    res.total = TOTAL_W'(total);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR result %0d %s: got 0x%0h expected 0x%0h", result_count, what, got,
             want);
    error_count++;
  endtask

  // Draw an idle length: mostly short, a few long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one sample request and record its expectation
  task automatic send_sample(logic [IDX_W-1:0] idx);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_sample_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    expected_samples.push_back(predict_sample(idx));
    request_count++;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    config_count++;
    case (idx)
      REG_CRUISE_SPEED: speed_q = data[SPEED_W-1:0];
      REG_START_POS:    start_q = data;
      REG_TARGET_POS:   target_q = data;
      default: ;
    endcase
  endtask

  task automatic set_move(logic [POS_W-1:0] s, logic [POS_W-1:0] t, logic [POS_W-1:0] v);
    drain();
    write_reg(REG_CRUISE_SPEED, v);
    write_reg(REG_START_POS, s);
    write_reg(REG_TARGET_POS, t);
  endtask

  // Hit both sides of every phase boundary of the current move
  task automatic send_edges();
    longint unsigned d, v, b, k;
    longint diff;
    diff = longint'(target_q) - longint'(start_q);
    d = diff < 0 ? -diff : diff;
    v = speed_q;
    send_sample(32'd0);
    for (int p = 0; p < 3; p++) begin
      b = (p == 0 ? 150 : p == 1 ? 500 : 650) * d;
      k = b / v;
      if (k > 0) send_sample(IDX_W'(k - 1));
      send_sample(IDX_W'(k));
      send_sample(IDX_W'(k + 1));
    end
    send_sample(32'hFFFF_FFFF);
  endtask

  task automatic test_error_cases();
    set_move(24'd100, 24'd100, 24'd50);
    send_sample(32'd0);
    send_sample(32'd12345);
    // Speed register keeps only its low bits: zero speed here
    set_move(24'd0, 24'd500, 24'hFF0000);
    send_sample(32'd7);
    // Unknown index, which the configuration registers ignore
    drain();
    write_reg(2'd3, 24'h123456);
  endtask

  task automatic test_phase_edges();
    set_move(24'd0, 24'd1000, 24'd13);          // exact hit on the move end
    send_edges();
    set_move(24'd1000, -24'sd1000, 24'd13);     // reverse direction
    send_edges();
  endtask

  task automatic test_extremes();
    set_move(24'h800000, 24'h7FFFFF, 24'hFFFF);
    send_edges();
    set_move(24'd5, 24'd6, 24'hFFFF);           // saturated acceleration
    send_sample(32'd0);
    send_sample(32'd1);
    set_move(24'h7FFFFF, 24'h800000, 24'd1);    // saturated total
    send_sample(32'd3);
  endtask

  task automatic test_random();
    logic [POS_W-1:0] s, t, v;
    longint unsigned span;
    int unsigned r;
    sample_t first;
    for (int m = 0; m < 26; m++) begin
      r = $urandom_range(0, 9);
      v = POS_W'(r < 2 ? 24'd1 : r < 4 ? 24'hFFFF : (r < 6 ? $urandom_range(1, 50)
                                                           : $urandom_range(0, 65535)));
      r = $urandom_range(0, 9);
      s = r < 2 ? 24'h800000 : r < 4 ? 24'h7FFFFF : POS_W'($urandom);
      r = $urandom_range(0, 9);
      if (r < 6) t = POS_W'(s + $urandom_range(0, 4000) - 2000);
      else t = POS_W'($urandom);
      if (m == 3) t = s;
      set_move(s, t, v);
      calm = ($urandom_range(0, 3) == 0);
      first = predict_sample(32'd0);
      span = first.total;
      span = span + span / 8 + 2;
      if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
      for (int n = 0; n < 58; n++) begin
        r = $urandom_range(0, 99);
        if (r < 85) send_sample(32'(({$urandom, $urandom} % (span + 1))));
        else send_sample($urandom);
      end
    end
    calm = 1'b0;
  endtask

  // Check each delivered result against the oldest expectation
  always @(posedge clk_i) begin
    sample_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_samples.size() == 0) begin
        $display("ERROR result %0d arrived with nothing expected", result_count);
        error_count++;
      end else begin
        want = expected_samples.pop_front();
        if (out_position_milli_o !== want.pos_milli)
          report_mismatch("position_milli", 64'(out_position_milli_o), 64'(want.pos_milli));
        if (out_velocity_o !== want.vel)
          report_mismatch("velocity", 64'(out_velocity_o), 64'(want.vel));
        if (out_acceleration_o !== want.acc)
          report_mismatch("acceleration", 64'(out_acceleration_o), 64'(want.acc));
        if (out_total_samples_o !== want.total)
          report_mismatch("total_samples", 64'(out_total_samples_o), 64'(want.total));
        if (out_move_done_o !== want.done)
          report_mismatch("move_done", 64'(out_move_done_o), 64'(want.done));
        if (out_profile_error_o !== want.err)
          report_mismatch("profile_error", 64'(out_profile_error_o), 64'(want.err));
      end
      result_count++;
    end
  end

  // Stall the result side at random, with calm stretches
  always @(posedge clk_i) begin
    int unsigned r;
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else begin
      if (r < 2) stall_left = $urandom_range(10, 40);
      out_stall_i <= (r < 25);
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_error_cases();
    test_phase_edges();
    test_extremes();
    test_random();
    drain();
    $display("Covered %0d sample requests and %0d results over %0d register writes,",
             request_count, result_count, config_count);
    $display("including zero moves, phase edges, both directions and saturation.");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/tmp_pkg.sv
rtl/core/tmp_coef.sv
rtl/core/tmp_front.sv
rtl/core/tmp_div_stage.sv
rtl/core/tmp_back.sv
rtl/core/trapezoid_motion_profile.sv
verif/trapezoid_motion_profile_tb.sv
